/* rtl/mts_pkg.sv */
// shared types and codes for the multi-timer scheduler
`default_nettype none
package mts_pkg;

	// deadline and seconds counter width
	localparam int DL_W = 32;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_PERIOD = 3'd1;
	localparam logic [2:0] ST_DUPLICATE  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

	// result kinds
	localparam logic KIND_RESPONSE = 1'b0;
	localparam logic KIND_EXPIRY   = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_APPLY,
		S_FIRE_SCAN,
		S_FIRE_APPLY,
		S_PEND_SCAN,
		S_EMIT_LOG,
		S_EMIT_LAST
	} mts_state_t;

endpackage
`default_nettype wire

/* rtl/multi_timer_scheduler.sv */
// top level of the multi-timer scheduler: sequencer, slot table and firing log
//
// A command is taken when start is high and busy is low. Add, remove and query
// each take two passes over the slot memory (id search, then earliest-deadline
// search); the one response appears in the first cycle in which busy is low,
// and the next command can be taken in that cycle. A tick takes one pass per
// fired timer plus one empty pass and the earliest-deadline pass. Its expiries,
// one per fired timer, come out on consecutive cycles, and the final response
// follows the last of them after a gap with result_valid low, in the first
// cycle in which busy is low. Each pass walks the single read port of the
// slot memory one entry per cycle. Results appear on the result ports for one
// cycle each, marked by result_valid, and cannot be held off; the last one of
// a command carries last_result. All results of one command report the time
// and earliest deadline as they stand after the whole command.
`default_nettype none
module multi_timer_scheduler
	import mts_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int ID_BITS     = 8,
	parameter int PERIOD_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             command,
	input  wire logic [ID_BITS-1:0]     timer_id,
	input  wire logic [PERIOD_BITS-1:0] period_seconds,
	input  wire logic                   repeat_flag,
	output logic                        result_valid,
	output logic                        result_kind,
	output logic [2:0]                  status_code,
	output logic [ID_BITS-1:0]          fired_or_queried_id,
	output logic [PERIOD_BITS-1:0]      period_out,
	output logic [DL_W-1:0]             due_time,
	output logic [DL_W-1:0]             now_time,
	output logic [DL_W-1:0]             next_due,
	output logic                        has_pending,
	output logic                        last_result
);

	localparam int IDXW = $clog2(SLOTS);
	localparam int CW   = IDXW + 1;
	localparam int SW   = ID_BITS + DL_W + PERIOD_BITS + 1;
	localparam int LW   = ID_BITS + PERIOD_BITS;

	mts_state_t state_q, state_d;

	// command registers
	logic [1:0]             cmd_q;
	logic [ID_BITS-1:0]     cmd_id_q;
	logic [PERIOD_BITS-1:0] cmd_period_q;
	logic                   cmd_rep_q;

	// slot bookkeeping
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] done_q;
	logic [DL_W-1:0]  now_q;

	// scan pipeline
	logic [CW-1:0]   rd_q;
	logic            vld_s1;
	logic [IDXW-1:0] idx_s1;
	logic            scan_state;
	logic            scan_end;

	// best or matching entry
	logic                   hit_q;
	logic [IDXW-1:0]        hit_idx_q;
	logic [ID_BITS-1:0]     hit_id_q;
	logic [DL_W-1:0]        hit_dl_q;
	logic [PERIOD_BITS-1:0] hit_period_q;
	logic                   hit_rep_q;

	// earliest pending deadline
	logic            pend_q;
	logic [DL_W-1:0] nd_q;

	// response fields
	logic [2:0]             rsp_status_q;
	logic [ID_BITS-1:0]     rsp_id_q;
	logic [PERIOD_BITS-1:0] rsp_period_q;
	logic [DL_W-1:0]        rsp_due_q;

	// firing log
	logic [CW-1:0] log_cnt_q;
	logic [CW-1:0] em_q;
	logic          em_vld_s1;

	// output registers
	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [2:0]             out_status_q;
	logic [ID_BITS-1:0]     out_id_q;
	logic [PERIOD_BITS-1:0] out_period_q;
	logic [DL_W-1:0]        out_due_q;
	logic [DL_W-1:0]        out_now_q;
	logic [DL_W-1:0]        out_nd_q;
	logic                   out_pend_q;
	logic                   out_last_q;

	// memory ports
	logic            slot_we;
	logic [IDXW-1:0] slot_waddr;
	logic [SW-1:0]   slot_wdata;
	logic [SW-1:0]   slot_rdata;
	logic            log_we;
	logic [LW-1:0]   log_rdata;

	logic [ID_BITS-1:0]     rd_id;
	logic [DL_W-1:0]        rd_dl;
	logic [PERIOD_BITS-1:0] rd_period;
	logic                   rd_rep;

	logic            free_found;
	logic [IDXW-1:0] free_idx;

	logic [PERIOD_BITS-1:0] sat_in;
	logic [DL_W:0]          sat_sum;
	logic [DL_W-1:0]        sat_dl;

	logic accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign rd_id     = slot_rdata[SW-1 -: ID_BITS];
	assign rd_dl     = slot_rdata[SW-ID_BITS-1 -: DL_W];
	assign rd_period = slot_rdata[PERIOD_BITS:1];
	assign rd_rep    = slot_rdata[0];

	assign scan_state = (state_q == S_FIND) || (state_q == S_FIRE_SCAN) ||
		(state_q == S_PEND_SCAN);
	assign scan_end   = scan_state && (rd_q == CW'(SLOTS)) && !vld_s1;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDXW'(i);
			end
		end
	end

	// saturating deadline: now plus period
	assign sat_in  = (state_q == S_APPLY) ? cmd_period_q : hit_period_q;
	assign sat_sum = {1'b0, now_q} + (DL_W + 1)'(sat_in);
	assign sat_dl  = sat_sum[DL_W] ? {DL_W{1'b1}} : sat_sum[DL_W-1:0];

	// slot memory write port
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = free_idx;
		slot_wdata = {cmd_id_q, sat_dl, cmd_period_q, cmd_rep_q};
		if (state_q == S_APPLY) begin
			slot_we = (cmd_q == CMD_ADD) && (cmd_period_q != '0) && !hit_q && free_found;
		end else if (state_q == S_FIRE_APPLY) begin
			slot_we    = hit_rep_q;
			slot_waddr = hit_idx_q;
			slot_wdata = {hit_id_q, sat_dl, hit_period_q, hit_rep_q};
		end
	end

	assign log_we = (state_q == S_FIRE_APPLY);

	mts_ram #(
		.WIDTH(SW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(rd_q[IDXW-1:0]),
		.rdata(slot_rdata)
	);

	mts_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_log_ram (
		.clk  (clk),
		.we   (log_we),
		.waddr(log_cnt_q[IDXW-1:0]),
		.wdata({hit_id_q, hit_period_q}),
		.raddr(em_q[IDXW-1:0]),
		.rdata(log_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (command == CMD_TICK) ? S_FIRE_SCAN : S_FIND;
				end
			end
			S_FIND: begin
				if (scan_end) state_d = S_APPLY;
			end
			S_APPLY: state_d = S_PEND_SCAN;
			S_FIRE_SCAN: begin
				if (scan_end) state_d = hit_q ? S_FIRE_APPLY : S_PEND_SCAN;
			end
			S_FIRE_APPLY: state_d = S_FIRE_SCAN;
			S_PEND_SCAN: begin
				if (scan_end) state_d = (log_cnt_q != '0) ? S_EMIT_LOG : S_EMIT_LAST;
			end
			S_EMIT_LOG: begin
				if ((em_q == log_cnt_q) && !em_vld_s1) state_d = S_EMIT_LAST;
			end
			S_EMIT_LAST: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			done_q      <= '0;
			now_q       <= '0;
			rd_q        <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			pend_q      <= 1'b0;
			log_cnt_q   <= '0;
			em_q        <= '0;
			em_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			em_vld_s1   <= 1'b0;

			// slot walk: one read a cycle, data in the cycle after
			vld_s1 <= scan_state && (rd_q < CW'(SLOTS));
			if (scan_end) begin
				rd_q <= '0;
			end else if (scan_state && (rd_q < CW'(SLOTS))) begin
				rd_q <= rd_q + CW'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q     <= 1'b0;
						pend_q    <= 1'b0;
						done_q    <= '0;
						log_cnt_q <= '0;
						em_q      <= '0;
						if (command == CMD_TICK) begin
							now_q <= now_q + DL_W'(1);
						end
					end
				end
				S_FIND: begin
					if (vld_s1 && valid_q[idx_s1] && (rd_id == cmd_id_q)) begin
						hit_q <= 1'b1;
					end
				end
				S_APPLY: begin
					if (slot_we) begin
						valid_q[free_idx] <= 1'b1;
					end else if ((cmd_q == CMD_REMOVE) && hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				S_FIRE_SCAN: begin
					if (vld_s1 && valid_q[idx_s1] && !done_q[idx_s1] && (rd_dl <= now_q) &&
						(!hit_q || (rd_dl < hit_dl_q) ||
						((rd_dl == hit_dl_q) && (rd_id < hit_id_q)))) begin
						hit_q <= 1'b1;
					end
				end
				S_FIRE_APPLY: begin
					hit_q             <= 1'b0;
					done_q[hit_idx_q] <= 1'b1;
					log_cnt_q         <= log_cnt_q + CW'(1);
					if (!hit_rep_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				S_PEND_SCAN: begin
					if (vld_s1 && valid_q[idx_s1]) begin
						pend_q <= 1'b1;
					end
				end
				S_EMIT_LOG: begin
					if (em_q != log_cnt_q) begin
						em_q      <= em_q + CW'(1);
						em_vld_s1 <= 1'b1;
					end
					if (em_vld_s1) begin
						out_valid_q <= 1'b1;
					end
				end
				S_EMIT_LAST: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDXW-1:0];

		if (accept) begin
			cmd_q        <= command;
			cmd_id_q     <= timer_id;
			cmd_period_q <= period_seconds;
			cmd_rep_q    <= repeat_flag;
		end

		// capture match or best due entry
		if (((state_q == S_FIND) && vld_s1 && valid_q[idx_s1] && (rd_id == cmd_id_q)) ||
			((state_q == S_FIRE_SCAN) && vld_s1 && valid_q[idx_s1] && !done_q[idx_s1] &&
			(rd_dl <= now_q) && (!hit_q || (rd_dl < hit_dl_q) ||
			((rd_dl == hit_dl_q) && (rd_id < hit_id_q))))) begin
			hit_idx_q    <= idx_s1;
			hit_id_q     <= rd_id;
			hit_dl_q     <= rd_dl;
			hit_period_q <= rd_period;
			hit_rep_q    <= rd_rep;
		end

		// earliest pending deadline
		if ((state_q == S_PEND_SCAN) && vld_s1 && valid_q[idx_s1] &&
			(!pend_q || (rd_dl < nd_q))) begin
			nd_q <= rd_dl;
		end

		// command response
		if (accept) begin
			rsp_status_q <= ST_OK;
			rsp_id_q     <= (command == CMD_TICK) ? '0 : timer_id;
			rsp_period_q <= '0;
			rsp_due_q    <= '0;
		end else if (state_q == S_APPLY) begin
			case (cmd_q)
				CMD_ADD: begin
					if (cmd_period_q == '0) begin
						rsp_status_q <= ST_BAD_PERIOD;
					end else if (hit_q) begin
						rsp_status_q <= ST_DUPLICATE;
					end else if (!free_found) begin
						rsp_status_q <= ST_FULL;
					end else begin
						rsp_due_q <= sat_dl;
					end
				end
				CMD_REMOVE: begin
					if (!hit_q) rsp_status_q <= ST_NOT_FOUND;
				end
				CMD_QUERY: begin
					if (!hit_q) begin
						rsp_status_q <= ST_NOT_FOUND;
					end else begin
						rsp_period_q <= hit_period_q;
						rsp_due_q    <= hit_dl_q;
					end
				end
				default: begin
				end
			endcase
		end

		// result register
		out_now_q  <= now_q;
		out_nd_q   <= pend_q ? nd_q : '0;
		out_pend_q <= pend_q;
		if (state_q == S_EMIT_LAST) begin
			out_kind_q   <= KIND_RESPONSE;
			out_status_q <= rsp_status_q;
			out_id_q     <= rsp_id_q;
			out_period_q <= rsp_period_q;
			out_due_q    <= rsp_due_q;
			out_last_q   <= 1'b1;
		end else begin
			out_kind_q   <= KIND_EXPIRY;
			out_status_q <= ST_OK;
			out_id_q     <= log_rdata[LW-1 -: ID_BITS];
			out_period_q <= log_rdata[PERIOD_BITS-1:0];
			out_due_q    <= now_q;
			out_last_q   <= 1'b0;
		end
	end

	assign result_valid        = out_valid_q;
	assign result_kind         = out_kind_q;
	assign status_code         = out_status_q;
	assign fired_or_queried_id = out_id_q;
	assign period_out          = out_period_q;
	assign due_time            = out_due_q;
	assign now_time            = out_now_q;
	assign next_due            = out_nd_q;
	assign has_pending         = out_pend_q;
	assign last_result         = out_last_q;

	// an expiry is never the final result of a command
	a_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind == KIND_EXPIRY)) |-> !last_result)
		else $error("expiry marked as last result");

	// an expiry always reports ok
	a_expiry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind == KIND_EXPIRY)) |-> (status_code == ST_OK))
		else $error("expiry with bad status");

	// firing log never overruns the table size
	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		log_cnt_q <= CW'(SLOTS))
		else $error("firing log overrun");

	// a firing slot is valid and not yet fired this tick
	a_fire_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIRE_APPLY) |-> (valid_q[hit_idx_q] && !done_q[hit_idx_q]))
		else $error("slot fired twice in one tick");

	// the final response closes the command in the following cycle
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_LAST) |=> (result_valid && last_result && !busy))
		else $error("final response missing");

endmodule
`default_nettype wire

/* rtl/mts_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
